// ----- sv/mac_fragmentation_calculator_assert.svh -----
// assertion macros shared by the fragmentation calculator modules
`ifndef MAC_FRAGMENTATION_CALCULATOR_ASSERT_SVH
`define MAC_FRAGMENTATION_CALCULATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MFC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fragmentation calculator check failed");

// next-cycle implication, checked out of reset
`define MFC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fragmentation calculator check failed");

`endif

// ----- sv/mfc_pkg.sv -----
`default_nettype none

package mfc_pkg;

    localparam int FIELD_BITS          = 16;
    localparam int SIZE_BITS_DEFAULT   = 16;
    localparam int CHECK_BYTES_DEFAULT = 4;

    localparam logic [15:0] MIN_THRESHOLD   = 16'd256;
    localparam logic [15:0] RESET_THRESHOLD = 16'd65534;

    // one query in flight through the divider chain
    typedef struct packed {
        logic [15:0] payload;
        logic [15:0] idx;
        logic [15:0] cap;
        logic        need;
        logic        err;
        logic [15:0] rem;
        logic [15:0] quot;
    } mfc_work_t;

    typedef struct packed {
        logic        need_fragmentation;
        logic [15:0] fragment_count;
        logic [15:0] fragment_bytes;
        logic [15:0] fragment_offset;
        logic        last_fragment;
        logic        index_valid;
        logic        config_error;
    } mfc_result_t;

    function automatic logic [15:0] clamp_threshold(input logic [15:0] value);
        logic [15:0] result;
        if (value < MIN_THRESHOLD) begin
            result = MIN_THRESHOLD;
        end else begin
            result = {value[15:1], 1'b0};
        end
        return result;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mfc_front.sv -----
`default_nettype none

module mfc_front #(
    parameter int SIZE_BITS   = mfc_pkg::SIZE_BITS_DEFAULT,
    parameter int CHECK_BYTES = mfc_pkg::CHECK_BYTES_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [15:0]       payload_size,
    input  wire logic [7:0]        header_size,
    input  wire logic [15:0]       fragment_index,
    input  wire logic              is_group,
    input  wire logic [15:0]       threshold,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfc_pkg::mfc_work_t     out_work
);

    localparam int DataBits = (SIZE_BITS < mfc_pkg::FIELD_BITS) ? SIZE_BITS
                                                                 : mfc_pkg::FIELD_BITS;
    localparam logic [15:0] SizeMask = 16'hFFFF >> (mfc_pkg::FIELD_BITS - DataBits);

    logic               valid_reg;
    mfc_pkg::mfc_work_t work_reg;
    mfc_pkg::mfc_work_t work_next;

    logic [8:0]  overhead;
    logic [15:0] payload_m;
    logic [15:0] thr_m;
    logic [16:0] total;

    always_comb begin
        overhead  = {1'b0, header_size} + 9'(CHECK_BYTES);
        payload_m = payload_size & SizeMask;
        thr_m     = threshold & SizeMask;
        total     = {1'b0, payload_m} + {8'b0, overhead};

        work_next.payload = payload_m;
        work_next.idx     = fragment_index;
        work_next.cap     = thr_m - {7'b0, overhead};
        work_next.err     = (thr_m <= {7'b0, overhead});
        work_next.need    = !is_group && (total > {1'b0, thr_m});
        work_next.rem     = '0;
        work_next.quot    = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mfc_div_cell.sv -----
`default_nettype none

// one restoring-division step: brings down one payload bit, settles one quotient bit
module mfc_div_cell #(
    parameter int BIT_POS = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mfc_pkg::mfc_work_t in_work,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfc_pkg::mfc_work_t     out_work
);

    logic               valid_reg;
    mfc_pkg::mfc_work_t work_reg;
    mfc_pkg::mfc_work_t work_next;

    logic [16:0] shifted;
    logic [16:0] diff;
    logic        fits;

    always_comb begin
        shifted   = {in_work.rem, in_work.payload[BIT_POS]};
        diff      = shifted - {1'b0, in_work.cap};
        fits      = (shifted >= {1'b0, in_work.cap});
        work_next = in_work;
        work_next.rem = fits ? diff[15:0] : shifted[15:0];
        work_next.quot[BIT_POS] = fits;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mfc_back.sv -----
`default_nettype none

// rounds the quotient up, places the indexed fragment and builds the result
module mfc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mfc_pkg::mfc_work_t in_work,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfc_pkg::mfc_result_t   out_result
);

    typedef struct packed {
        logic [15:0] payload;
        logic [15:0] cap;
        logic [15:0] count;
        logic [15:0] offset;
        logic        idx_ok;
        logic        last;
        logic        need;
        logic        err;
    } mfc_mid_t;

    logic     a_valid_reg;
    mfc_mid_t a_reg;
    mfc_mid_t a_next;
    logic     b_valid_reg;
    mfc_pkg::mfc_result_t b_reg;
    mfc_pkg::mfc_result_t b_next;
    logic     b_ready;

    logic [16:0] count_wide;
    logic [31:0] product;

    always_comb begin
        count_wide = {1'b0, in_work.quot} + {16'b0, (in_work.rem != '0)};
        product    = {16'b0, in_work.idx} * {16'b0, in_work.cap};

        a_next.payload = in_work.payload;
        a_next.cap     = in_work.cap;
        a_next.count   = count_wide[15:0];
        a_next.offset  = product[15:0];
        a_next.idx_ok  = (in_work.idx < count_wide[15:0]);
        a_next.last    = (in_work.idx < count_wide[15:0])
                         && (in_work.idx == (count_wide[15:0] - 16'd1));
        a_next.need    = in_work.need;
        a_next.err     = in_work.err;
    end

    always_comb begin
        b_next = '0;
        if (a_reg.err) begin
            b_next.config_error = 1'b1;
        end else begin
            b_next.need_fragmentation = a_reg.need;
            b_next.fragment_count     = a_reg.count;
            b_next.index_valid        = a_reg.idx_ok;
            b_next.last_fragment      = a_reg.last;
            if (a_reg.idx_ok) begin
                b_next.fragment_offset = a_reg.offset;
                b_next.fragment_bytes  = a_reg.last ? (a_reg.payload - a_reg.offset)
                                                    : a_reg.cap;
            end
        end
    end

    assign b_ready    = !b_valid_reg || out_ready;
    assign in_ready   = !a_valid_reg || b_ready;
    assign out_valid  = b_valid_reg;
    assign out_result = b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_reg <= a_next;
        end
        if (b_ready && a_valid_reg) begin
            b_reg <= b_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mfc_skid.sv -----
`default_nettype none

`include "mac_fragmentation_calculator_assert.svh"

// output register with a skid entry so the ready seen upstream is registered
module mfc_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mfc_pkg::mfc_result_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mfc_pkg::mfc_result_t     out_data
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    mfc_pkg::mfc_result_t out_data_reg;
    mfc_pkg::mfc_result_t skid_data_reg;
    logic                 in_fire;
    logic                 out_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

    // the skid entry only fills behind a held output beat
    `MFC_ASSERT_IMPL(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)

endmodule

`default_nettype wire

// ----- sv/mac_fragmentation_calculator.sv -----
// channel  | direction | handshake                 | content
// s_       | in        | s_tvalid / s_tready       | one fragment query per beat
// m_       | out       | m_tvalid / m_tready       | one fragment result per beat
// cfg_     | in        | cfg_valid / cfg_ready     | fragmentation threshold write
//
// one query accepted per cycle while s_tready is high; each query passes through, in order:
// one input stage, one restoring-divider cell per payload bit, two finishing stages
// (multiply for the offset, then selection) and the output register.
// aresetn is synchronous, active low; it empties the pipeline and sets the threshold
// to 65534. a stalled output holds one beat in the output register and one in the skid
// entry, then the stages behind fill; s_tready drops with min(SIZE_BITS,16)+5 beats
// held (21 at 16 bits). threshold writes are always taken and apply to later queries.
`default_nettype none

`include "mac_fragmentation_calculator_assert.svh"

module mac_fragmentation_calculator #(
    parameter int SIZE_BITS   = mfc_pkg::SIZE_BITS_DEFAULT,
    parameter int CHECK_BYTES = mfc_pkg::CHECK_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // payload_size, header_size, fragment_index
    input  wire logic [0:0]  s_tuser,    // is_group
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // need_fragmentation, fragment_count,
                                         // fragment_bytes, fragment_offset,
                                         // last_fragment, index_valid, config_error
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data    // frag_threshold
);

    localparam int DataBits = (SIZE_BITS < mfc_pkg::FIELD_BITS) ? SIZE_BITS
                                                                 : mfc_pkg::FIELD_BITS;

    logic [15:0] thr_reg;
    logic [15:0] thr_next;

    logic [DataBits:0]  chain_valid;
    logic [DataBits:0]  chain_ready;
    mfc_pkg::mfc_work_t chain_work [DataBits+1];

    logic                 back_valid;
    logic                 back_ready;
    mfc_pkg::mfc_result_t back_result;
    mfc_pkg::mfc_result_t res;

    logic thr_legal;
    logic err_clean;
    logic valid_sane;

    assign cfg_ready = 1'b1;
    assign thr_next  = mfc_pkg::clamp_threshold(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= mfc_pkg::RESET_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= thr_next;
        end
    end

    mfc_front #(
        .SIZE_BITS   (SIZE_BITS),
        .CHECK_BYTES (CHECK_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .payload_size   (s_tdata[15:0]),
        .header_size    (s_tdata[23:16]),
        .fragment_index (s_tdata[39:24]),
        .is_group       (s_tuser[0]),
        .threshold      (thr_reg),
        .out_valid      (chain_valid[0]),
        .out_ready      (chain_ready[0]),
        .out_work       (chain_work[0])
    );

    // most significant payload bit is brought down first
    for (genvar k = 0; k < DataBits; k++) begin : g_cell
        mfc_div_cell #(
            .BIT_POS (DataBits - 1 - k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_work   (chain_work[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_work  (chain_work[k+1])
        );
    end

    mfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[DataBits]),
        .in_ready   (chain_ready[DataBits]),
        .in_work    (chain_work[DataBits]),
        .out_valid  (back_valid),
        .out_ready  (back_ready),
        .out_result (back_result)
    );

    mfc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (back_valid),
        .in_ready  (back_ready),
        .in_data   (back_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {4'b0,
                      res.config_error,
                      res.index_valid,
                      res.last_fragment,
                      res.fragment_offset,
                      res.fragment_bytes,
                      res.fragment_count,
                      res.need_fragmentation};

    assign thr_legal  = (thr_reg[0] == 1'b0) && (thr_reg >= mfc_pkg::MIN_THRESHOLD);
    assign err_clean  = (res.fragment_count == 16'd0) && !res.need_fragmentation
                        && !res.index_valid;
    assign valid_sane = (res.fragment_count != 16'd0) && (res.fragment_bytes != 16'd0);

    `MFC_ASSERT_IMPL(a_thr_legal, aclk, aresetn, 1'b1, thr_legal)
    `MFC_ASSERT_NEXT(a_thr_write, aclk, aresetn, cfg_valid && cfg_ready, thr_reg == $past(thr_next))
    `MFC_ASSERT_IMPL(a_err_clears, aclk, aresetn, m_tvalid && res.config_error, err_clean)
    `MFC_ASSERT_IMPL(a_last_in_range, aclk, aresetn, m_tvalid && res.last_fragment, res.index_valid)
    `MFC_ASSERT_IMPL(a_valid_nonempty, aclk, aresetn, m_tvalid && res.index_valid, valid_sane)

endmodule

`default_nettype wire

// ----- sim/tb_mac_fragmentation_calculator.sv -----
`timescale 1ns / 1ps

module tb_mac_fragmentation_calculator;

    localparam int CHECK_OVERHEAD = 4;
    localparam int DRAIN_CYCLES   = 25;
    localparam int TAIL_CYCLES    = 40;
    localparam int HOLD_CYCLES    = 180;
    localparam int STALL_LIMIT    = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PER_SET = 215;

    typedef struct {
        logic [15:0] payload;
        logic [7:0]  header;
        logic [15:0] idx;
        logic        grp;
    } frag_query_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // payload_size, header_size, fragment_index
    logic [0:0]  s_tuser = '0;    // is_group
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // need_fragmentation, fragment_count, fragment_bytes,
                                  // fragment_offset, last_fragment, index_valid,
                                  // config_error
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    frag_query_t          query_q[$];
    mfc_pkg::mfc_result_t frag_expect_q[$];
    logic [15:0]          cur_threshold = mfc_pkg::RESET_THRESHOLD;

    bit          query_fire = 1'b0;
    bit          result_fire = 1'b0;
    int          fail_count = 0;
    int          stall_cycles = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          hold_req = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          ready_mode = 0;
    int          mode_left = 0;
    frag_query_t next_query;
    mfc_pkg::mfc_result_t got_result;
    mfc_pkg::mfc_result_t exp_result;

    mac_fragmentation_calculator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic mfc_pkg::mfc_result_t predict_fragment(input logic [15:0] thr,
                                                              input frag_query_t q);
        mfc_pkg::mfc_result_t r;
        int          overhead;
        int          cap;
        int          count;
        int          offs;
        r        = '0;
        overhead = int'(q.header) + CHECK_OVERHEAD;
        if (int'(thr) <= overhead) begin
            r.config_error = 1'b1;
            return r;
        end
        cap   = int'(thr) - overhead;
        count = (int'(q.payload) + cap - 1) / cap;
        r.need_fragmentation = !q.grp && (int'(q.payload) + overhead > int'(thr));
        r.fragment_count     = count[15:0];
        if (int'(q.idx) < count) begin
            offs              = int'(q.idx) * cap;
            r.index_valid     = 1'b1;
            r.last_fragment   = (int'(q.idx) == count - 1);
            r.fragment_offset = offs[15:0];
            r.fragment_bytes  = r.last_fragment ? 16'(int'(q.payload) - offs) : cap[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] clamped_threshold(input logic [15:0] v);
        if (v < 16'd256) begin
            return 16'd256;
        end
        return v & 16'hFFFE;
    endfunction

    // mostly well-formed queries: indexes near the fragment count, payloads on boundaries
    function automatic frag_query_t random_query(input logic [15:0] thr);
        frag_query_t q;
        int          overhead;
        int          cap;
        int          count;
        int          k;
        case ($urandom_range(9, 0))
            0: q.header = 8'($urandom);
            1: q.header = 8'($urandom_range(255, 240));
            default: q.header = 8'($urandom_range(64, 0));
        endcase
        overhead = int'(q.header) + CHECK_OVERHEAD;
        cap      = (int'(thr) > overhead) ? int'(thr) - overhead : 1;
        case ($urandom_range(5, 0))
            0: q.payload = 16'($urandom);
            1: q.payload = 16'($urandom_range(15, 0));
            2: begin
                k         = $urandom_range(65535 / cap, 1);
                q.payload = 16'(k * cap);
            end
            default: begin
                k         = $urandom_range(8 * int'(thr), 0);
                q.payload = (k > 65535) ? 16'hFFFF : 16'(k);
            end
        endcase
        count = (int'(q.payload) + cap - 1) / cap;
        case ($urandom_range(9, 0))
            0: q.idx = 16'($urandom);
            1: q.idx = '0;
            2, 3: q.idx = (count > 0) ? 16'(count - 1) : '0;
            default: q.idx = 16'($urandom_range(count, 0));
        endcase
        q.grp = ($urandom_range(3, 0) == 0);
        return q;
    endfunction

    task automatic add_query(input logic [15:0] payload, input logic [7:0] header,
                             input logic [15:0] idx, input logic grp);
        frag_query_t q;
        q.payload = payload;
        q.header  = header;
        q.idx     = idx;
        q.grp     = grp;
        query_q   = {query_q, q};
    endtask

    // threshold writes only once the pipeline has emptied
    task automatic write_threshold(input logic [15:0] value);
        while (query_q.size() != 0 || s_tvalid || frag_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cur_threshold = clamped_threshold(value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // query driver: bursts of random length, random gaps between them
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || query_fire)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (query_q.size() > 0) begin
                next_query = query_q.pop_front();
                s_tdata    <= {next_query.idx, next_query.header, next_query.payload};
                s_tuser    <= next_query.grp;
                s_tvalid   <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(24, 1);
                    case ($urandom_range(3, 0))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(40, 10);
                        default: gap_left = $urandom_range(6, 1);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern changes now and then, plus the long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_req) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(3, 0);
                mode_left  = $urandom_range(512, 64);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3, 0) != 0);
                2: m_tready <= ($urandom_range(3, 0) == 0);
                default: m_tready <= (mode_left % 4 == 0);
            endcase
        end
    end

    // beat monitor, result check and watchdog
    always @(posedge aclk) begin
        query_fire  = aresetn && s_tvalid && s_tready;
        result_fire = aresetn && m_tvalid && m_tready;
        if (query_fire) begin
            next_query.payload = s_tdata[15:0];
            next_query.header  = s_tdata[23:16];
            next_query.idx     = s_tdata[39:24];
            next_query.grp     = s_tuser[0];
            frag_expect_q = {frag_expect_q, predict_fragment(cur_threshold, next_query)};
        end
        if (result_fire) begin
            got_result.need_fragmentation = m_tdata[0];
            got_result.fragment_count     = m_tdata[16:1];
            got_result.fragment_bytes     = m_tdata[32:17];
            got_result.fragment_offset    = m_tdata[48:33];
            got_result.last_fragment      = m_tdata[49];
            got_result.index_valid        = m_tdata[50];
            got_result.config_error       = m_tdata[51];
            if (frag_expect_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result beat: %h", m_tdata);
                end
            end else begin
                exp_result = frag_expect_q.pop_front();
                if (got_result !== exp_result) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result mismatch: need/count/bytes/offset/last/valid/err");
                        $display("  expected %0d %0d %0d %0d %0d %0d %0d",
                                 exp_result.need_fragmentation, exp_result.fragment_count,
                                 exp_result.fragment_bytes, exp_result.fragment_offset,
                                 exp_result.last_fragment, exp_result.index_valid,
                                 exp_result.config_error);
                        $display("  actual   %0d %0d %0d %0d %0d %0d %0d",
                                 got_result.need_fragmentation, got_result.fragment_count,
                                 got_result.fragment_bytes, got_result.fragment_offset,
                                 got_result.last_fragment, got_result.index_valid,
                                 got_result.config_error);
                    end
                end
            end
        end
        if (query_fire || result_fire || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    logic [15:0] threshold_set[9] = '{16'hFFFF, 16'd257, 16'd1500, 16'd2347, 16'd300,
                                      16'h0000, 16'd1024, 16'd255, 16'd65534};

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset threshold: boundaries around the largest threshold
        add_query(16'd0,     8'd0,   16'd0,     1'b0);
        add_query(16'hFFFF,  8'd255, 16'd0,     1'b0);
        add_query(16'hFFFF,  8'd255, 16'd1,     1'b0);
        add_query(16'hFFFF,  8'd255, 16'd2,     1'b0);
        add_query(16'hFFFF,  8'd255, 16'hFFFF,  1'b1);
        add_query(16'd65530, 8'd0,   16'd0,     1'b0);
        add_query(16'd65531, 8'd0,   16'd1,     1'b0);
        add_query(16'd1,     8'd0,   16'd0,     1'b0);

        // smallest threshold: capacity of one byte, none at all, exact multiples
        write_threshold(16'd0);
        add_query(16'd1000,  8'd255, 16'd0,     1'b0);
        add_query(16'd1000,  8'd252, 16'd0,     1'b0);
        add_query(16'hFFFF,  8'd251, 16'd65534, 1'b0);
        add_query(16'hFFFF,  8'd251, 16'hFFFF,  1'b0);
        add_query(16'hFFFF,  8'd251, 16'd0,     1'b1);
        add_query(16'd252,   8'd0,   16'd0,     1'b0);
        add_query(16'd253,   8'd0,   16'd1,     1'b0);
        add_query(16'd504,   8'd0,   16'd1,     1'b0);
        add_query(16'd0,     8'd255, 16'd0,     1'b0);
        add_query(16'hAAAA,  8'h55,  16'h5555,  1'b1);
        add_query(16'h5555,  8'hAA,  16'd2,     1'b0);

        foreach (threshold_set[p]) begin
            if (p == 7) begin
                write_threshold(16'($urandom));
            end else begin
                write_threshold(threshold_set[p]);
            end
            repeat (RANDOM_PER_SET) query_q = {query_q, random_query(cur_threshold)};
            if (p == 1) begin
                hold_req++;
            end
        end

        while (query_q.size() != 0 || s_tvalid || frag_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && frag_expect_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
